@@ rtl/hdcu_pkg.sv @@
package hdcu_pkg;

	localparam int NEIGHBORS_DEF = 4;

	localparam int TEMP_W  = 16;
	localparam int KIND_W  = 2;
	localparam int CFG_W   = 16;

	// neighbour terms are carried in units of 2^-12 degree
	localparam int FRAC_SHIFT = 12;
	localparam int GAIN_SHIFT = 28;
	localparam int TERM_W     = 34;
	localparam int LO_W       = 18;

	// stream packing
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 24;
	localparam int NBR_BASE    = 35;
	localparam int NBR_STRIDE  = 18;

	localparam logic [CFG_W-1:0] GAIN_RST  = 16'd6554;   // 0.1 in Q0.16
	localparam logic [CFG_W-1:0] COEFF_RST = 16'd4096;   // 1.0 in Q4.12
	localparam logic [CFG_W-1:0] FLUX_RST  = 16'd0;

	localparam logic [KIND_W-1:0] CELL_INTERIOR = 2'd0;

	typedef enum logic [1:0] {
		REG_GAIN  = 2'd0,
		REG_COEFF = 2'd1,
		REG_FLUX  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		NB_ABSENT     = 2'd0,
		NB_INTERIOR   = 2'd1,
		NB_INSULATED  = 2'd2,
		NB_CONVECTIVE = 2'd3
	} nbr_kind_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} adv_t;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [TEMP_W-1:0] temp;
		logic                     ext_valid;
		logic signed [TEMP_W-1:0] ext_temp;
	} cell_meta_t;

endpackage

@@ rtl/hdcu_nbr_term.sv @@
module hdcu_nbr_term (
	input  logic                                   clk,
	input  hdcu_pkg::adv_t                         adv,
	input  logic [1:0]                             nbr_kind,
	input  logic signed [hdcu_pkg::TEMP_W-1:0]     nbr_temp,
	input  logic signed [hdcu_pkg::TEMP_W-1:0]     cell_temp,
	input  logic signed [hdcu_pkg::CFG_W-1:0]      flux,
	input  logic [hdcu_pkg::CFG_W-1:0]             coeff,
	output logic signed [hdcu_pkg::TERM_W-1:0]     term_s2
);

	localparam int TW = hdcu_pkg::TERM_W;
	localparam int DW = hdcu_pkg::TEMP_W + 1;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0]  diff_s1;
	logic signed [DW-1:0]  fm_s1;
	hdcu_pkg::nbr_kind_t   kind_s1;

	logic signed [PW-1:0]  cprod;
	logic signed [TW-1:0]  dsh;
	logic signed [TW-1:0]  fsh;
	logic signed [TW-1:0]  term;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			diff_s1 <= DW'(nbr_temp) - DW'(cell_temp);
			fm_s1   <= DW'(flux) - DW'(cell_temp);
			kind_s1 <= hdcu_pkg::nbr_kind_t'(nbr_kind);
		end
	end

	assign cprod = $signed({1'b0, coeff}) * diff_s1;
	assign dsh   = TW'(diff_s1) <<< hdcu_pkg::FRAC_SHIFT;
	assign fsh   = TW'(fm_s1) <<< hdcu_pkg::FRAC_SHIFT;

	// each counted neighbour already carries its share of minus t
	always_comb begin
		case (kind_s1)
			hdcu_pkg::NB_INTERIOR:   term = dsh;
			hdcu_pkg::NB_CONVECTIVE: term = fsh + TW'(cprod);
			default:                 term = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			term_s2 <= term;
		end
	end

endmodule

@@ rtl/hdcu_scale.sv @@
module hdcu_scale #(
	parameter int NEIGHBORS = hdcu_pkg::NEIGHBORS_DEF
) (
	input  logic                                                    clk,
	input  hdcu_pkg::adv_t                                          adv,
	input  logic [hdcu_pkg::CFG_W-1:0]                              gain,
	input  logic signed [hdcu_pkg::TERM_W+$clog2(NEIGHBORS)-1:0]    d_s3,
	input  hdcu_pkg::cell_meta_t                                    meta_s3,
	output logic signed [hdcu_pkg::TEMP_W-1:0]                      new_temp,
	output logic [hdcu_pkg::KIND_W-1:0]                             kind_out
);

	localparam int D_W     = hdcu_pkg::TERM_W + $clog2(NEIGHBORS);
	localparam int LO_W    = hdcu_pkg::LO_W;
	localparam int HI_W    = D_W - LO_W;
	localparam int G_W     = hdcu_pkg::CFG_W;
	localparam int LOP_W   = LO_W + G_W;
	localparam int HIP_W   = HI_W + G_W + 1;
	localparam int PROD_W  = D_W + G_W + 1;
	localparam int DELTA_W = PROD_W - hdcu_pkg::GAIN_SHIFT;
	localparam int SUM_W   = DELTA_W + 1;
	localparam int TW      = hdcu_pkg::TEMP_W;

	localparam logic signed [SUM_W-1:0] T_MAX = SUM_W'(32'sd32767);
	localparam logic signed [SUM_W-1:0] T_MIN = SUM_W'(-32'sd32768);

	logic [LOP_W-1:0]          lo_s4;
	logic signed [HIP_W-1:0]   hi_s4;
	hdcu_pkg::cell_meta_t      meta_s4;

	logic signed [PROD_W-1:0]  prod;
	logic signed [DELTA_W-1:0] delta;
	logic signed [SUM_W-1:0]   upd;
	logic signed [TW-1:0]      sat;
	logic signed [TW-1:0]      res;

	logic signed [TW-1:0]      new_temp_s5;
	logic [hdcu_pkg::KIND_W-1:0] kind_s5;

	// split the gain product into two narrow partial products
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			lo_s4   <= LOP_W'(d_s3[LO_W-1:0]) * LOP_W'(gain);
			hi_s4   <= HIP_W'($signed(d_s3[D_W-1:LO_W])) * HIP_W'($signed({1'b0, gain}));
			meta_s4 <= meta_s3;
		end
	end

	assign prod  = (PROD_W'(hi_s4) <<< LO_W) + PROD_W'($signed({1'b0, lo_s4}));
	assign delta = DELTA_W'(prod >>> hdcu_pkg::GAIN_SHIFT);
	assign upd   = SUM_W'(meta_s4.temp) + SUM_W'(delta);

	always_comb begin
		if (upd > T_MAX) begin
			sat = TW'(T_MAX);
		end else if (upd < T_MIN) begin
			sat = TW'(T_MIN);
		end else begin
			sat = TW'(upd);
		end
	end

	always_comb begin
		if (meta_s4.ext_valid) begin
			res = meta_s4.ext_temp;
		end else if (meta_s4.kind != hdcu_pkg::CELL_INTERIOR) begin
			res = meta_s4.temp;
		end else begin
			res = sat;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			new_temp_s5 <= res;
			kind_s5     <= meta_s4.kind;
		end
	end

	assign new_temp = new_temp_s5;
	assign kind_out = kind_s5;

endmodule

@@ rtl/heat_diffusion_cell_update_unit.sv @@
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  one cell with its neighbours
// m_axis    out  m_axis_tvalid / m_axis_tready  updated temperature and kind
// cfg       in   cfg_valid / cfg_ready          register index and write data
//
// One cell a cycle while the output is not stalled.
// Stages: lane differences, lane coefficient multiply, neighbour sum,
// split gain multiply, floor/saturate/select into the output register.
// Each stage moves when it is empty or the next one moves, so bubbles close up
// and input keeps flowing while the output beat waits, until no empty stage is left.
// arst_n clears the valid bits and loads the register reset values.
module heat_diffusion_cell_update_unit #(
	parameter int NEIGHBORS = hdcu_pkg::NEIGHBORS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// cell_kind[1:0] cell_temp[17:2] ext_valid[18] ext_temp[34:19]
	// nbr0_kind nbr0_temp nbr1_kind nbr1_temp nbr2_kind nbr2_temp
	// nbr3_kind nbr3_temp (2 + 16 bits each from bit 35), zero pad
	input  logic [hdcu_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// new_temp[15:0] kind_out[17:16], zero pad
	output logic [hdcu_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [1:0]                            cfg_index,
	input  logic [hdcu_pkg::CFG_W-1:0]            cfg_data
);

	localparam int TW  = hdcu_pkg::TEMP_W;
	localparam int D_W = hdcu_pkg::TERM_W + $clog2(NEIGHBORS);
	localparam int NB  = hdcu_pkg::NBR_BASE;
	localparam int NS  = hdcu_pkg::NBR_STRIDE;

	logic [hdcu_pkg::CFG_W-1:0]        gain_q;
	logic [hdcu_pkg::CFG_W-1:0]        coeff_q;
	logic signed [hdcu_pkg::CFG_W-1:0] flux_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	hdcu_pkg::adv_t adv;

	hdcu_pkg::cell_meta_t meta_in;
	hdcu_pkg::cell_meta_t meta_s1, meta_s2, meta_s3;

	logic signed [hdcu_pkg::TERM_W-1:0] term_s2 [NEIGHBORS];
	logic signed [D_W-1:0]              acc;
	logic signed [D_W-1:0]              d_s3;

	logic signed [TW-1:0]               new_temp;
	logic [hdcu_pkg::KIND_W-1:0]        kind_out;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= hdcu_pkg::GAIN_RST;
			coeff_q <= hdcu_pkg::COEFF_RST;
			flux_q  <= hdcu_pkg::FLUX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (hdcu_pkg::cfg_reg_t'(cfg_index))
				hdcu_pkg::REG_GAIN:  gain_q  <= cfg_data;
				hdcu_pkg::REG_COEFF: coeff_q <= cfg_data;
				hdcu_pkg::REG_FLUX:  flux_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	always_comb begin
		adv.s5 = !valid_s5 || m_axis_tready;
		adv.s4 = !valid_s4 || adv.s5;
		adv.s3 = !valid_s3 || adv.s4;
		adv.s2 = !valid_s2 || adv.s3;
		adv.s1 = !valid_s1 || adv.s2;
	end

	assign s_axis_tready = adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv.s1) valid_s1 <= s_axis_tvalid;
			if (adv.s2) valid_s2 <= valid_s1;
			if (adv.s3) valid_s3 <= valid_s2;
			if (adv.s4) valid_s4 <= valid_s3;
			if (adv.s5) valid_s5 <= valid_s4;
		end
	end

	// cell fields ride alongside the neighbour lanes
	assign meta_in.kind      = s_axis_tdata[1:0];
	assign meta_in.temp      = s_axis_tdata[17:2];
	assign meta_in.ext_valid = s_axis_tdata[18];
	assign meta_in.ext_temp  = s_axis_tdata[34:19];

	always_ff @(posedge clk) begin
		if (adv.s1) meta_s1 <= meta_in;
		if (adv.s2) meta_s2 <= meta_s1;
		if (adv.s3) meta_s3 <= meta_s2;
	end

	for (genvar i = 0; i < NEIGHBORS; i++) begin : g_lane
		hdcu_nbr_term u_term (
			.clk       (clk),
			.adv       (adv),
			.nbr_kind  (s_axis_tdata[NB + NS*i +: 2]),
			.nbr_temp  (s_axis_tdata[NB + NS*i + 2 +: TW]),
			.cell_temp (meta_in.temp),
			.flux      (flux_q),
			.coeff     (coeff_q),
			.term_s2   (term_s2[i])
		);
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NEIGHBORS; i++) begin
			acc = acc + D_W'(term_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) d_s3 <= acc;
	end

	hdcu_scale #(
		.NEIGHBORS (NEIGHBORS)
	) u_scale (
		.clk      (clk),
		.adv      (adv),
		.gain     (gain_q),
		.d_s3     (d_s3),
		.meta_s3  (meta_s3),
		.new_temp (new_temp),
		.kind_out (kind_out)
	);

	assign m_axis_tvalid = valid_s5;
	assign m_axis_tdata  = {6'b0, kind_out, new_temp};

	// an empty output register never blocks the input
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s5 |-> s_axis_tready)
		else $error("input stalled with an empty output stage");

	// an accepted beat lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted beat lost at stage 1");

	// a full stage holds only behind a stalled output
	a_hold_behind_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !adv.s4) |-> (valid_s5 && !m_axis_tready))
		else $error("stage 4 held without a downstream stall");

	// a stalled stage 4 beat is still there next cycle
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !adv.s5) |=> valid_s4)
		else $error("stage 4 beat dropped during stall");

endmodule

@@ tb/sv/heat_diffusion_cell_update_unit_tb.sv @@
module heat_diffusion_cell_update_unit_tb;
	import hdcu_pkg::*;

	localparam logic [KIND_W-1:0] CELL_INSULATED  = 2'd1;
	localparam logic [KIND_W-1:0] CELL_CONVECTIVE = 2'd2;
	localparam logic [KIND_W-1:0] CELL_UNUSED     = 2'd3;

	localparam logic [TEMP_W-1:0] T_MAX = 16'h7fff;
	localparam logic [TEMP_W-1:0] T_MIN = 16'h8000;

	localparam int STALL_LIMIT    = 4000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES  = 10;
	localparam int PHASE_CELLS    = 125;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic [KIND_W-1:0]        kind;
	} cell_result_t;

	logic clk;
	logic arst_n = 1'b0;

	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [1:0]             cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;

	// register shadow used for prediction
	logic [CFG_W-1:0]        diff_gain  = GAIN_RST;
	logic [CFG_W-1:0]        conv_coeff = COEFF_RST;
	logic signed [CFG_W-1:0] conv_flux  = FLUX_RST;

	logic [IN_TDATA_W-1:0] pending_cells[$];
	cell_result_t          expected_temps[$];

	int  tx_idle_pct = 0;
	int  rx_stall_pct = 0;
	int  rx_hold_req = 0;
	int  rx_hold_seen = 0;
	int  rx_hold_left = 0;
	bit  s_beat_done = 1'b0;
	int  mismatches = 0;
	int  quiet_cycles = 0;

	heat_diffusion_cell_update_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic cell_result_t diffuse_cell(input logic [IN_TDATA_W-1:0] beat);
		cell_result_t             r;
		logic signed [TEMP_W-1:0] t;
		logic signed [TEMP_W-1:0] nt;
		nbr_kind_t                nk;
		longint                   acc;
		longint                   cnt;
		longint                   d;
		longint                   res;
		int                       i;
		r.kind = beat[1:0];
		t = beat[17:2];
		res = longint'(t);
		if (beat[18]) begin
			r.temp = beat[34:19];
			return r;
		end
		if (r.kind == CELL_INTERIOR) begin
			acc = 0;
			cnt = 0;
			for (i = 0; i < NEIGHBORS_DEF; i++) begin
				nk = nbr_kind_t'(beat[NBR_BASE + NBR_STRIDE*i +: KIND_W]);
				nt = beat[NBR_BASE + NBR_STRIDE*i + KIND_W +: TEMP_W];
				case (nk)
					NB_INTERIOR: begin
						acc += longint'(nt) * 4096;
						cnt++;
					end
					NB_CONVECTIVE: begin
						acc += longint'(conv_flux) * 4096
							+ longint'(conv_coeff) * (longint'(nt) - longint'(t));
						cnt++;
					end
					default: ;
				endcase
			end
			d = acc - cnt * longint'(t) * 4096;
			// arithmetic shift floors towards minus infinity
			res = longint'(t) + ((longint'(diff_gain) * d) >>> GAIN_SHIFT);
			if (res > 32767) res = 32767;
			if (res < -32768) res = -32768;
		end
		r.temp = res[TEMP_W-1:0];
		return r;
	endfunction

	task automatic push_cell(input logic [KIND_W-1:0] ck, input logic [TEMP_W-1:0] t,
			input logic ev, input logic [TEMP_W-1:0] et,
			input logic [4*KIND_W-1:0] nks, input logic [4*TEMP_W-1:0] nts);
		logic [IN_TDATA_W-1:0] beat;
		int                    i;
		beat = '0;
		beat[1:0]   = ck;
		beat[17:2]  = t;
		beat[18]    = ev;
		beat[34:19] = et;
		for (i = 0; i < 4; i++) begin
			beat[NBR_BASE + NBR_STRIDE*i +: KIND_W] = nks[KIND_W*i +: KIND_W];
			beat[NBR_BASE + NBR_STRIDE*i + KIND_W +: TEMP_W] = nts[TEMP_W*i +: TEMP_W];
		end
		pending_cells.push_back(beat);
	endtask

	function automatic logic [TEMP_W-1:0] pick_temp(input logic [TEMP_W-1:0] base);
		logic [TEMP_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = 16'($urandom);
			1: v = T_MAX;
			2: v = T_MIN;
			default: v = base + TEMP_W'($urandom_range(0, 511)) - 16'd256;
		endcase
		return v;
	endfunction

	// mostly interior cells without forcing, the rest boundary, forced or odd kinds
	task automatic push_random_cell();
		logic [KIND_W-1:0]   ck;
		logic [TEMP_W-1:0]   t;
		logic                ev;
		logic [4*KIND_W-1:0] nks;
		logic [4*TEMP_W-1:0] nts;
		int                  i;
		ck = ($urandom_range(0, 99) < 75) ? CELL_INTERIOR : KIND_W'($urandom_range(1, 3));
		ev = ($urandom_range(0, 99) < 10);
		t = ($urandom_range(0, 9) == 0) ? pick_temp(16'($urandom)) : 16'($urandom);
		nks = 8'($urandom);
		for (i = 0; i < 4; i++)
			nts[TEMP_W*i +: TEMP_W] = pick_temp(t);
		push_cell(ck, t, ev, 16'($urandom), nks, nts);
	endtask

	task automatic wait_drained();
		while (pending_cells.size() != 0 || expected_temps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GAIN:  diff_gain  = val;
			REG_COEFF: conv_coeff = val;
			REG_FLUX:  conv_flux  = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] c,
			input logic [CFG_W-1:0] f);
		wait_drained();
		write_reg(REG_GAIN, g);
		write_reg(REG_COEFF, c);
		write_reg(REG_FLUX, f);
	endtask

	// input driver: hold an offered beat until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!(s_axis_tvalid && !s_beat_done)) begin
			if (pending_cells.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= pending_cells[0];
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		s_beat_done = 1'b0;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			expected_temps.push_back(diffuse_cell(s_axis_tdata));
			void'(pending_cells.pop_front());
			s_beat_done = 1'b1;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_hold_seen != rx_hold_req) begin
			rx_hold_seen = rx_hold_req;
			rx_hold_left = RX_HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		cell_result_t want;
		logic signed [TEMP_W-1:0] got_temp;
		logic [KIND_W-1:0]        got_kind;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_temp = m_axis_tdata[15:0];
			got_kind = m_axis_tdata[17:16];
			if (expected_temps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output beat: temp %0d kind %0d", got_temp, got_kind);
			end else begin
				want = expected_temps.pop_front();
				if (got_temp !== want.temp) begin
					mismatches++;
					if (mismatches <= 10)
						$display("new_temp mismatch: expected %0d, got %0d", want.temp, got_temp);
				end
				if (got_kind !== want.kind) begin
					mismatches++;
					if (mismatches <= 10)
						$display("kind_out mismatch: expected %0d, got %0d", want.kind, got_kind);
				end
			end
		end
	end

	// watchdog: count cycles with work outstanding and no beat moving
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)
				|| (pending_cells.size() == 0 && expected_temps.size() == 0 && !cfg_valid)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int p;
		int n;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset register values
		push_cell(CELL_INTERIOR, 16'd1000, 1'b0, 16'd0,
			{NB_INTERIOR, NB_INTERIOR, NB_INTERIOR, NB_INTERIOR},
			{16'd2000, 16'd2000, 16'd2000, 16'd2000});
		push_cell(CELL_INTERIOR, 16'd777, 1'b0, T_MAX,
			{NB_ABSENT, NB_ABSENT, NB_ABSENT, NB_ABSENT}, {4{T_MIN}});
		push_cell(CELL_INTERIOR, 16'hfc00, 1'b0, T_MIN,
			{NB_INSULATED, NB_INSULATED, NB_INSULATED, NB_INSULATED}, {4{T_MAX}});
		// small negative step floors to minus one
		push_cell(CELL_INTERIOR, 16'd0, 1'b0, 16'd0,
			{NB_ABSENT, NB_ABSENT, NB_ABSENT, NB_INTERIOR}, {48'd0, 16'hffff});
		push_cell(CELL_INTERIOR, 16'd100, 1'b0, 16'd0,
			{NB_CONVECTIVE, NB_CONVECTIVE, NB_CONVECTIVE, NB_CONVECTIVE}, {4{16'd300}});
		push_cell(CELL_INTERIOR, 16'd50, 1'b1, T_MIN,
			{NB_INTERIOR, NB_INTERIOR, NB_INTERIOR, NB_INTERIOR}, {4{T_MAX}});
		push_cell(CELL_INSULATED, T_MIN, 1'b1, T_MAX,
			{NB_CONVECTIVE, NB_INTERIOR, NB_INSULATED, NB_ABSENT}, {4{16'd0}});
		push_cell(CELL_INSULATED, 16'hfffb, 1'b0, 16'd9,
			{NB_INTERIOR, NB_INTERIOR, NB_INTERIOR, NB_INTERIOR}, {4{T_MAX}});
		push_cell(CELL_CONVECTIVE, T_MAX, 1'b0, T_MIN,
			{NB_CONVECTIVE, NB_CONVECTIVE, NB_CONVECTIVE, NB_CONVECTIVE}, {4{T_MIN}});
		push_cell(CELL_CONVECTIVE, 16'd3, 1'b1, 16'hff00,
			{NB_INTERIOR, NB_ABSENT, NB_INTERIOR, NB_ABSENT}, {4{16'd5}});
		push_cell(CELL_UNUSED, 16'd1234, 1'b0, 16'd0,
			{NB_INTERIOR, NB_INTERIOR, NB_INTERIOR, NB_INTERIOR}, {4{T_MIN}});
		push_cell(CELL_UNUSED, 16'd1, 1'b1, 16'hbeef,
			{NB_INTERIOR, NB_INTERIOR, NB_INTERIOR, NB_INTERIOR}, {4{T_MIN}});
		push_cell(CELL_INTERIOR, T_MAX, 1'b0, 16'hffff,
			{NB_INTERIOR, NB_INTERIOR, NB_INTERIOR, NB_INTERIOR}, {4{T_MAX}});

		// largest gain, coefficient and flux drive saturation
		write_all(16'hffff, 16'hffff, T_MAX);
		push_cell(CELL_INTERIOR, T_MIN, 1'b0, 16'd0,
			{NB_INTERIOR, NB_INTERIOR, NB_INTERIOR, NB_INTERIOR}, {4{T_MAX}});
		push_cell(CELL_INTERIOR, T_MAX, 1'b0, 16'd0,
			{NB_CONVECTIVE, NB_CONVECTIVE, NB_CONVECTIVE, NB_CONVECTIVE}, {4{T_MIN}});
		push_cell(CELL_INTERIOR, 16'd0, 1'b0, 16'd0,
			{NB_CONVECTIVE, NB_CONVECTIVE, NB_CONVECTIVE, NB_CONVECTIVE}, {4{16'd0}});
		push_cell(CELL_INTERIOR, 16'd20, 1'b0, 16'd0,
			{NB_CONVECTIVE, NB_INSULATED, NB_INTERIOR, NB_ABSENT},
			{16'd40, 16'hffd0, 16'd30, 16'd10});

		// zero gain leaves the cell alone
		write_all(16'd0, 16'hffff, T_MIN);
		push_cell(CELL_INTERIOR, 16'd500, 1'b0, 16'd0,
			{NB_INTERIOR, NB_INTERIOR, NB_INTERIOR, NB_INTERIOR}, {4{16'd30000}});

		write_all(16'hffff, 16'hffff, T_MIN);
		push_cell(CELL_INTERIOR, 16'd0, 1'b0, 16'd0,
			{NB_CONVECTIVE, NB_CONVECTIVE, NB_CONVECTIVE, NB_CONVECTIVE}, {4{16'd0}});
		push_cell(CELL_INTERIOR, T_MIN, 1'b0, 16'd0,
			{NB_CONVECTIVE, NB_CONVECTIVE, NB_CONVECTIVE, NB_CONVECTIVE}, {4{T_MIN}});

		// hold the output off while input keeps coming, so the pipe backs up
		write_all(GAIN_RST, COEFF_RST, FLUX_RST);
		rx_hold_req++;
		for (n = 0; n < 60; n++)
			push_random_cell();
		// pause the sender until every result is back
		wait_drained();
		repeat (40) @(posedge clk);

		for (p = 0; p < 8; p++) begin
			case (p)
				0: write_all(GAIN_RST, COEFF_RST, FLUX_RST);
				1: write_all(16'hffff, 16'hffff, T_MAX);
				2: write_all(16'd0, 16'd0, T_MIN);
				3: write_all(16'($urandom_range(0, 16384)), 16'($urandom), 16'($urandom));
				default: write_all(16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
				default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
			endcase
			for (n = 0; n < PHASE_CELLS; n++)
				push_random_cell();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_temps.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ heat_diffusion_cell_update_unit.f @@
rtl/hdcu_pkg.sv
rtl/hdcu_nbr_term.sv
rtl/hdcu_scale.sv
rtl/heat_diffusion_cell_update_unit.sv
tb/sv/heat_diffusion_cell_update_unit_tb.sv
